FILE: rtl/hfvs_pkg.sv
// ---------------------------------------------------------------------------
// hfvs_pkg
// Types and constants shared by the heading-frame steering block.
// ---------------------------------------------------------------------------
package hfvs_pkg;

    localparam int TABLE_LEN = 24;
    // vector datapath: 16-bit input << 8, grows by CORDIC gain (<1.65) and
    // by the rotation (sqrt 2): 16+8+2 bits plus headroom
    localparam int VW = 28;
    // angle datapath in units of 2^-24 rad
    localparam int AW = 28;

    localparam logic signed [AW-1:0] ANG_PI      = AW'(52707179);
    localparam logic signed [AW-1:0] ANG_HALF_PI = AW'(26353589);
    localparam logic signed [31:0]   INV_GAIN_Q30 = 32'sd652032874;

    typedef enum logic [1:0] {
        REG_MAX_SPEED   = 2'd0,
        REG_STEER_GAIN  = 2'd1,
        REG_STEER_LIMIT = 2'd2
    } t_reg_idx;

    function automatic logic signed [AW-1:0] atan_tab(input int unsigned i);
        logic signed [AW-1:0] r;
        case (i)
            0:  r = AW'(13176795);
            1:  r = AW'(7778716);
            2:  r = AW'(4110060);
            3:  r = AW'(2086331);
            4:  r = AW'(1047214);
            5:  r = AW'(524117);
            6:  r = AW'(262123);
            7:  r = AW'(131069);
            default: r = (i < 24) ? (AW'(1) <<< (24 - i)) : '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/hfvs_if.sv
// ---------------------------------------------------------------------------
// hfvs_in_if / hfvs_out_if
// Valid/ready channels for input commands and steering results.
// ---------------------------------------------------------------------------
interface hfvs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] heading;
    logic signed [15:0] world_vx;
    logic signed [15:0] world_vy;
    modport source (output valid, heading, world_vx, world_vy, input ready);
    modport sink   (input valid, heading, world_vx, world_vy, output ready);
endinterface

interface hfvs_out_if;
    logic               valid;
    logic               ready;
    logic        [14:0] forward_speed;
    logic signed [15:0] turn_rate;
    modport source (output valid, forward_speed, turn_rate, input ready);
    modport sink   (input valid, forward_speed, turn_rate, output ready);
endinterface

FILE: rtl/hfvs_cordic_stage.sv
// ---------------------------------------------------------------------------
// hfvs_cordic_stage
// One registered CORDIC micro-rotation; rotation or vectoring mode.
// ---------------------------------------------------------------------------
module hfvs_cordic_stage #(
    parameter int SHIFT = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [hfvs_pkg::VW-1:0]   i_x,
    input  logic signed [hfvs_pkg::VW-1:0]   i_y,
    input  logic signed [hfvs_pkg::AW-1:0]   i_z,
    output logic signed [hfvs_pkg::VW-1:0]   o_x,
    output logic signed [hfvs_pkg::VW-1:0]   o_y,
    output logic signed [hfvs_pkg::AW-1:0]   o_z
);
    localparam logic signed [hfvs_pkg::AW-1:0] ATAN = hfvs_pkg::atan_tab(SHIFT);
    logic                               w_pos;
    logic signed [hfvs_pkg::VW-1:0]    n_x, n_y;
    logic signed [hfvs_pkg::AW-1:0]    n_z;
    logic signed [hfvs_pkg::VW-1:0]    r_x, r_y;
    logic signed [hfvs_pkg::AW-1:0]    r_z;

    // rotation: z >= 0 turns ccw; vectoring: y < 0 turns ccw
    assign w_pos = VECTOR ? i_y[hfvs_pkg::VW-1] : !i_z[hfvs_pkg::AW-1];

    always_comb begin
        if (w_pos) begin
            n_x = i_x - (i_y >>> SHIFT);
            n_y = i_y + (i_x >>> SHIFT);
            n_z = VECTOR ? i_z - ATAN : i_z - ATAN;
        end else begin
            n_x = i_x + (i_y >>> SHIFT);
            n_y = i_y - (i_x >>> SHIFT);
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

FILE: rtl/heading_frame_velocity_steer_unit.sv
// ---------------------------------------------------------------------------
// heading_frame_velocity_steer_unit
// Rotates a world velocity command into the body frame and derives forward
// speed and a saturated turn rate from the body-frame bearing.
// ---------------------------------------------------------------------------
// Channel   Dir  Payload                          Transaction
// s_in      in   heading, world_vx, world_vy      valid & ready
// s_out     out  forward_speed, turn_rate         valid & ready
// apb       in   max_speed, steer_gain, limit     psel & penable & pwrite
//
// One item per cycle while the output is not held; with N = min(CORDIC_STAGES,24)
// the stages are: prefold, N rotation stages, gain-removal multiply, round, prep,
// N vectoring stages, gain multiply, clamp into the output register.
// All stages advance together; a held output stalls the whole pipe, and
// s_in.ready follows the output side (last register empty or taken).
// Synchronous active-low reset clears valid bits and loads config defaults.
// ---------------------------------------------------------------------------
module heading_frame_velocity_steer_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hfvs_in_if.sink     s_in,
    hfvs_out_if.source  s_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int VW = hfvs_pkg::VW;
    localparam int AW = hfvs_pkg::AW;
    localparam int N  = (CORDIC_STAGES < hfvs_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                               : hfvs_pkg::TABLE_LEN;
    localparam int LAT = 2 * N + 6;

    // ---------------- configuration ----------------
    logic [14:0] r_max_speed, r_steer_limit;
    logic [3:0]  r_steer_gain;
    hfvs_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_idx  = hfvs_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed   <= 15'd2048;
            r_steer_gain  <= 4'd5;
            r_steer_limit <= 15'd4096;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (w_idx)
                hfvs_pkg::REG_MAX_SPEED:   r_max_speed   <= pwdata[14:0];
                hfvs_pkg::REG_STEER_GAIN:  r_steer_gain  <= pwdata[3:0];
                hfvs_pkg::REG_STEER_LIMIT: r_steer_limit <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (w_idx)
                hfvs_pkg::REG_MAX_SPEED:   prdata = {17'd0, r_max_speed};
                hfvs_pkg::REG_STEER_GAIN:  prdata = {28'd0, r_steer_gain};
                hfvs_pkg::REG_STEER_LIMIT: prdata = {17'd0, r_steer_limit};
                default:                   prdata = '0;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign w_en       = !r_vld[LAT-1] || s_out.ready;
    assign s_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_in.valid};
        end
    end
    assign s_out.valid = r_vld[LAT-1];

    // ---------------- stage 0: fold rotation angle ----------------
    logic signed [AW-1:0] w_z0;
    logic signed [VW-1:0] w_x0, w_y0;
    logic signed [VW-1:0] r_x0, r_y0;
    logic signed [AW-1:0] r_z0;

    assign w_z0 = -(AW'(s_in.heading) <<< 11);
    assign w_x0 = VW'(s_in.world_vx) <<< 8;
    assign w_y0 = VW'(s_in.world_vy) <<< 8;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_z0 > hfvs_pkg::ANG_HALF_PI) begin
                r_z0 <= w_z0 - hfvs_pkg::ANG_PI; r_x0 <= -w_x0; r_y0 <= -w_y0;
            end else if (w_z0 < -hfvs_pkg::ANG_HALF_PI) begin
                r_z0 <= w_z0 + hfvs_pkg::ANG_PI; r_x0 <= -w_x0; r_y0 <= -w_y0;
            end else begin
                r_z0 <= w_z0; r_x0 <= w_x0; r_y0 <= w_y0;
            end
        end
    end

    // ---------------- rotation stages ----------------
    logic signed [VW-1:0] w_rx [N+1];
    logic signed [VW-1:0] w_ry [N+1];
    logic signed [AW-1:0] w_rz [N+1];
    assign w_rx[0] = r_x0;
    assign w_ry[0] = r_y0;
    assign w_rz[0] = r_z0;

    for (genvar g = 0; g < N; g++) begin : g_rot
        hfvs_cordic_stage #(.SHIFT(g), .VECTOR(1'b0)) u_stage (
            .i_clk(i_clk), .i_en(w_en),
            .i_x(w_rx[g]), .i_y(w_ry[g]), .i_z(w_rz[g]),
            .o_x(w_rx[g+1]), .o_y(w_ry[g+1]), .o_z(w_rz[g+1])
        );
    end

    // ---------------- gain removal: multiply, then round ----------------
    logic signed [VW+31:0] r_px, r_py;
    logic signed [VW-1:0]  r_bx, r_by;
    logic signed [VW+31:0] w_rnd_x, w_rnd_y;

    assign w_rnd_x = r_px + (VW+32)'(64'sd1 <<< 29);
    assign w_rnd_y = r_py + (VW+32)'(64'sd1 <<< 29);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= (VW+32)'(w_rx[N]) * (VW+32)'(hfvs_pkg::INV_GAIN_Q30);
            r_py <= (VW+32)'(w_ry[N]) * (VW+32)'(hfvs_pkg::INV_GAIN_Q30);
            r_bx <= VW'(w_rnd_x >>> 30);
            r_by <= VW'(w_rnd_y >>> 30);
        end
    end

    // ---------------- vectoring prep + forward speed ----------------
    logic signed [VW-1:0] r_vx, r_vy;
    logic signed [AW-1:0] r_va;
    logic [14:0]          r_fwd_p;
    logic [VW-1:0]        w_fwd_full;

    assign w_fwd_full = (VW'(r_bx) + VW'(128)) >> 8;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_bx <= 0)
                r_fwd_p <= '0;
            else if (w_fwd_full > VW'(r_max_speed))
                r_fwd_p <= r_max_speed;
            else
                r_fwd_p <= w_fwd_full[14:0];
            if (r_bx == 0 && r_by == 0) begin
                // zero vector: bearing 0; stages leave (0,0) untouched but add
                // angles, so mark with the zero flag r_zero_p below
                r_vx <= '0; r_vy <= '0; r_va <= '0;
            end else if (r_bx < 0) begin
                r_vx <= -r_bx; r_vy <= -r_by;
                r_va <= (r_by >= 0) ? hfvs_pkg::ANG_PI : -hfvs_pkg::ANG_PI;
            end else begin
                r_vx <= r_bx; r_vy <= r_by; r_va <= '0;
            end
        end
    end

    // zero-vector flag and forward speed travel beside the vectoring stages
    logic          r_zero_p;
    logic          r_zero_d [N+1];
    logic [14:0]   r_fwd_d [N+1];

    always_ff @(posedge i_clk) begin
        if (w_en) r_zero_p <= (r_bx == 0 && r_by == 0);
    end
    assign r_zero_d[0] = r_zero_p;
    assign r_fwd_d[0]  = r_fwd_p;

    logic signed [VW-1:0] w_vx [N+1];
    logic signed [VW-1:0] w_vy [N+1];
    logic signed [AW-1:0] w_va [N+1];
    assign w_vx[0] = r_vx;
    assign w_vy[0] = r_vy;
    assign w_va[0] = r_va;

    for (genvar g = 0; g < N; g++) begin : g_vec
        hfvs_cordic_stage #(.SHIFT(g), .VECTOR(1'b1)) u_stage (
            .i_clk(i_clk), .i_en(w_en),
            .i_x(w_vx[g]), .i_y(w_vy[g]), .i_z(w_va[g]),
            .o_x(w_vx[g+1]), .o_y(w_vy[g+1]), .o_z(w_va[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_zero_d[g+1] <= r_zero_d[g];
                r_fwd_d[g+1]  <= r_fwd_d[g];
            end
        end
    end

    // ---------------- gain, round, clamp, output ----------------
    logic signed [AW+4:0] r_prod;
    logic [14:0]          r_fwd_m, r_fwd_o;
    logic signed [AW+4:0] w_t;
    logic signed [AW+4:0] w_lim;
    logic signed [15:0]   r_turn_o;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod  <= r_zero_d[N] ? '0
                     : (AW+5)'(w_va[N]) * $signed({1'b0, r_steer_gain});
            r_fwd_m <= r_fwd_d[N];
        end
    end

    assign w_t   = (r_prod + (AW+5)'(2048)) >>> 12;
    assign w_lim = (AW+5)'(r_steer_limit);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fwd_o <= r_fwd_m;
            if (w_t > w_lim)
                r_turn_o <= 16'(w_lim);
            else if (w_t < -w_lim)
                r_turn_o <= 16'(-w_lim);
            else
                r_turn_o <= 16'(w_t);
        end
    end

    assign s_out.forward_speed = r_fwd_o;
    assign s_out.turn_rate     = r_turn_o;

endmodule
